>>> rtl/ceg_pkg.sv
// ceg_pkg: shared types, register codes and constants for the compressor
// envelope and gain block. No dependencies.
`timescale 1ns / 1ps

package ceg_pkg;

    localparam int LEVEL_BITS_DEF = 24;
    localparam int HOLD_BITS_DEF  = 20;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_ATTACK    = 3'd0;
    localparam logic [2:0] REG_RELEASE   = 3'd1;
    localparam logic [2:0] REG_HOLD      = 3'd2;
    localparam logic [2:0] REG_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_KNEE      = 3'd4;
    localparam logic [2:0] REG_SLOPE     = 3'd5;
    localparam logic [2:0] REG_MAKEUP    = 3'd6;

    localparam logic [1:0] PH_ATTACK  = 2'd0;
    localparam logic [1:0] PH_HOLD    = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    localparam logic signed [15:0] DB_FLOOR = -16'sd25600;

    localparam logic [25:0] HORNER_C [6] = '{
        26'd22370, 26'd161365, 26'd931204, 26'd4030332, 26'd11629080, 26'd16777216
    };

    typedef struct packed {
        logic [23:0]        attack_coef;
        logic [23:0]        release_coef;
        logic signed [15:0] threshold_db;
        logic [12:0]        knee_width_db;
        logic signed [15:0] ratio_slope;
        logic [12:0]        makeup_db;
    } cfg_t;

    // signed shift right, rounding half away from zero
    function automatic logic signed [PROD_W-1:0] rround(
        input logic signed [PROD_W-1:0] a, input int unsigned n);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] r;
        mag = a[PROD_W-1] ? PROD_W'(-a) : PROD_W'(a);
        r = (mag + (PROD_W'(1) << (n - 1))) >> n;
        return a[PROD_W-1] ? $signed(PROD_W'(-r)) : $signed(r);
    endfunction

endpackage

>>> rtl/compressor_envelope_gain.sv
// Compressor envelope follower and gain computer: stream wrapper and
// configuration registers. Depends on ceg_pkg, ceg_seq.
`timescale 1ns / 1ps

// Usage: one detector level word enters on the s_ channel per sample; one
// word leaves on the m_ channel with the linear gain and the updated
// envelope. Write the registers over the APB port only while the block is
// idle; the block itself does not enforce it. A word passes through one
// update step, two multiply steps for the envelope outside hold, a
// one-bit-per-cycle normalize of the envelope, 16 squaring steps and one
// scale step for the log, a knee select step, 16 divide steps plus 7
// multiply steps in the soft knee region, one slope step, one log2 scale step,
// 6 Horner steps and a final shift for the exponential, and the output step,
// all sharing one 33 x 33 multiplier. A zero envelope skips the log and a
// saturated or vanishing gain skips the exponential. s_tready is high only
// between words, so a new word is taken only once the last has left the
// sequencer. A finished word sits in the output register; if the receiver
// stalls the block holds the next result until the register frees.
// Reset clears the envelope, hold counter and output valid, sets the release
// phase and loads the register defaults.
module compressor_envelope_gain #(
    parameter int LEVEL_BITS = ceg_pkg::LEVEL_BITS_DEF,
    parameter int HOLD_BITS  = ceg_pkg::HOLD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // level_in
    input  logic [((LEVEL_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // gain_out, envelope_out
    output logic [((24+LEVEL_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ceg_pkg::ADDR_W-1:0]       paddr,
    input  logic [ceg_pkg::DATA_W-1:0]       pwdata,
    output logic [ceg_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);
    import ceg_pkg::*;

    localparam int OUT_W = ((24 + LEVEL_BITS + 7) / 8) * 8;

    cfg_t                 cfg_reg, cfg_next;
    logic [HOLD_BITS-1:0] hold_reg, hold_next;
    logic [2:0]           idx;
    logic                 wr;
    logic [23:0]          gain_w;
    logic [LEVEL_BITS-1:0] env_w;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next  = cfg_reg;
        hold_next = hold_reg;
        if (wr) begin
            unique case (idx)
                REG_ATTACK:    cfg_next.attack_coef   = pwdata[23:0];
                REG_RELEASE:   cfg_next.release_coef  = pwdata[23:0];
                REG_HOLD:      hold_next              = pwdata[HOLD_BITS-1:0];
                REG_THRESHOLD: cfg_next.threshold_db  = pwdata[15:0];
                REG_KNEE:      cfg_next.knee_width_db = pwdata[12:0];
                REG_SLOPE:     cfg_next.ratio_slope   = pwdata[15:0];
                REG_MAKEUP:    cfg_next.makeup_db     = pwdata[12:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ATTACK:    prdata = DATA_W'(cfg_reg.attack_coef);
            REG_RELEASE:   prdata = DATA_W'(cfg_reg.release_coef);
            REG_HOLD:      prdata = DATA_W'(hold_reg);
            REG_THRESHOLD: prdata = DATA_W'(cfg_reg.threshold_db);
            REG_KNEE:      prdata = DATA_W'(cfg_reg.knee_width_db);
            REG_SLOPE:     prdata = DATA_W'(cfg_reg.ratio_slope);
            REG_MAKEUP:    prdata = DATA_W'(cfg_reg.makeup_db);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_coef   <= 24'd1048576;
            cfg_reg.release_coef  <= 24'd65536;
            cfg_reg.threshold_db  <= -16'sd5120;
            cfg_reg.knee_width_db <= '0;
            cfg_reg.ratio_slope   <= -16'sd16384;
            cfg_reg.makeup_db     <= '0;
            hold_reg              <= HOLD_BITS'(480);
        end else begin
            cfg_reg  <= cfg_next;
            hold_reg <= hold_next;
        end
    end

    ceg_seq #(
        .LEVEL_BITS(LEVEL_BITS),
        .HOLD_BITS (HOLD_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .hold_count  (hold_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .level_in    (s_tdata[LEVEL_BITS-1:0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .gain_out    (gain_w),
        .envelope_out(env_w)
    );

    assign m_tdata = OUT_W'({env_w, gain_w});

endmodule

>>> rtl/ceg_mul.sv
// ceg_mul: shared signed 33 x 33 multiplier used by the sequencer.
// Depends on ceg_pkg.
`timescale 1ns / 1ps

module ceg_mul (
    input  logic signed [ceg_pkg::MUL_W-1:0]  a,
    input  logic signed [ceg_pkg::MUL_W-1:0]  b,
    output logic signed [ceg_pkg::PROD_W-1:0] p
);
    import ceg_pkg::*;

    assign p = PROD_W'(a) * PROD_W'(b);

endmodule

>>> rtl/ceg_seq.sv
// ceg_seq: sequencer for envelope update, log, knee, gain and exp steps,
// all products through one shared ceg_mul. Depends on ceg_pkg, ceg_mul.
`timescale 1ns / 1ps

module ceg_seq #(
    parameter int LEVEL_BITS = ceg_pkg::LEVEL_BITS_DEF,
    parameter int HOLD_BITS  = ceg_pkg::HOLD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ceg_pkg::cfg_t         cfg,
    input  logic [HOLD_BITS-1:0]  hold_count,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [LEVEL_BITS-1:0] level_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [23:0]           gain_out,
    output logic [LEVEL_BITS-1:0] envelope_out
);
    import ceg_pkg::*;

    localparam int PW = $clog2(LEVEL_BITS);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_UPD   = 5'd1;
    localparam logic [4:0] S_POLE1 = 5'd2;
    localparam logic [4:0] S_POLE2 = 5'd3;
    localparam logic [4:0] S_NORM0 = 5'd4;
    localparam logic [4:0] S_NORM  = 5'd5;
    localparam logic [4:0] S_SQR   = 5'd6;
    localparam logic [4:0] S_DB    = 5'd7;
    localparam logic [4:0] S_GAIN0 = 5'd8;
    localparam logic [4:0] S_DIV   = 5'd9;
    localparam logic [4:0] S_COSY  = 5'd10;
    localparam logic [4:0] S_COSZ  = 5'd11;
    localparam logic [4:0] S_COSA  = 5'd12;
    localparam logic [4:0] S_COSB  = 5'd13;
    localparam logic [4:0] S_COSC  = 5'd14;
    localparam logic [4:0] S_COSD  = 5'd15;
    localparam logic [4:0] S_COSV  = 5'd16;
    localparam logic [4:0] S_SLOPE = 5'd17;
    localparam logic [4:0] S_L2    = 5'd18;
    localparam logic [4:0] S_HORN  = 5'd19;
    localparam logic [4:0] S_FIN   = 5'd20;
    localparam logic [4:0] S_OUT   = 5'd21;

    logic [4:0]             st_reg, st_next;
    logic [LEVEL_BITS-1:0]  lvl_reg, lvl_next;
    logic [LEVEL_BITS-1:0]  env_reg, env_next;
    logic [1:0]             phase_reg, phase_next;
    logic [HOLD_BITS:0]     hcnt_reg, hcnt_next;
    logic [23:0]            coef_reg, coef_next;
    logic [56:0]            acc_reg, acc_next;
    logic [LEVEL_BITS-1:0]  norm_reg, norm_next;
    logic [PW-1:0]          p_reg, p_next;
    logic [30:0]            m_reg, m_next;
    logic [15:0]            frac_reg, frac_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic signed [15:0]     db_reg, db_next;
    logic signed [17:0]     x_reg, x_next;
    logic [12:0]            rem_reg, rem_next;
    logic [15:0]            q_reg, q_next;
    logic [17:0]            y_reg, y_next;
    logic [17:0]            z_reg, z_next;
    logic signed [18:0]     v_reg, v_next;
    logic signed [19:0]     gdb_reg, gdb_next;
    logic [15:0]            f_reg, f_next;
    logic [4:0]             n_reg, n_next;
    logic [23:0]            gain_reg, gain_next;
    logic                   ovalid_reg, ovalid_next;
    logic [23:0]            ogain_reg, ogain_next;
    logic [LEVEL_BITS-1:0]  oenv_reg, oenv_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0]        pu;

    logic [24:0]              one_minus_c;
    logic [21:0]              mag;
    logic [31:0]              aligned;
    logic [15:0]              u_w;
    logic [PROD_W-1:0]        sum_w;
    logic [31:0]              sq;
    logic [16:0]              dbm;
    logic signed [18:0]       e2, t2m, t2p, wsg;
    logic signed [17:0]       x_w, ax;
    logic [13:0]              rem2;
    logic signed [PROD_W-1:0] rr;
    logic [20:0]              off;
    logic [26:0]              fsum, fsh;
    logic                     attack;

    ceg_mul u_mul (.a(mul_a), .b(mul_b), .p(mul_p));

    assign pu          = mul_p;
    assign one_minus_c = 25'(1 << 24) - {1'b0, coef_reg};
    assign mag         = (22'(LEVEL_BITS) - 22'(p_reg)) * 22'(65536) - 22'(frac_reg);
    assign aligned     = 32'(norm_reg) << (32 - LEVEL_BITS);
    assign u_w         = (q_reg > 16'd32768) ? 16'd32768 : q_reg;
    assign e2          = 19'(db_reg) + 19'(db_reg);
    assign wsg         = $signed({6'b0, cfg.knee_width_db});
    assign t2m         = 19'(cfg.threshold_db) + 19'(cfg.threshold_db) - wsg;
    assign t2p         = 19'(cfg.threshold_db) + 19'(cfg.threshold_db) + wsg;
    assign x_w         = 18'(db_reg) - 18'(cfg.threshold_db);
    assign ax          = x_w[17] ? -x_w : x_w;
    assign rem2        = {rem_reg, 1'b0};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (st_reg)
            S_POLE1: begin
                mul_a = MUL_W'(one_minus_c);
                mul_b = MUL_W'(env_reg);
            end
            S_POLE2: begin
                mul_a = MUL_W'(coef_reg);
                mul_b = MUL_W'(lvl_reg);
            end
            S_SQR: begin
                mul_a = MUL_W'(m_reg);
                mul_b = MUL_W'(m_reg);
            end
            S_DB: begin
                mul_a = MUL_W'(mag);
                mul_b = MUL_W'(394566);
            end
            S_COSY: begin
                mul_a = MUL_W'(u_w);
                mul_b = MUL_W'(205887);
            end
            S_COSZ: begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'(y_reg);
            end
            S_COSA: begin
                mul_a = MUL_W'(z_reg);
                mul_b = MUL_W'(416);
            end
            S_COSB, S_COSC, S_COSD: begin
                mul_a = MUL_W'(z_reg);
                mul_b = MUL_W'(acc_reg[23:0]);
            end
            S_COSV: begin
                mul_a = MUL_W'(cfg.knee_width_db);
                mul_b = MUL_W'(acc_reg[23:0]);
            end
            S_SLOPE: begin
                mul_a = MUL_W'(cfg.ratio_slope);
                mul_b = MUL_W'(v_reg);
            end
            S_L2: begin
                mul_a = MUL_W'(gdb_reg);
                mul_b = MUL_W'(174164);
            end
            S_HORN: begin
                mul_a = MUL_W'(f_reg);
                mul_b = MUL_W'(acc_reg[25:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        st_next     = st_reg;
        lvl_next    = lvl_reg;
        env_next    = env_reg;
        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        coef_next   = coef_reg;
        acc_next    = acc_reg;
        norm_next   = norm_reg;
        p_next      = p_reg;
        m_next      = m_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        db_next     = db_reg;
        x_next      = x_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        v_next      = v_reg;
        gdb_next    = gdb_reg;
        f_next      = f_reg;
        n_next      = n_reg;
        gain_next   = gain_reg;
        ogain_next  = ogain_reg;
        oenv_next   = oenv_reg;
        ovalid_next = ovalid_reg && !out_ready;
        sum_w       = '0;
        sq          = '0;
        dbm         = '0;
        rr          = '0;
        off         = '0;
        fsum        = '0;
        fsh         = '0;
        attack      = (lvl_reg > env_reg) || (phase_reg == PH_ATTACK);

        unique case (st_reg)
            S_IDLE: begin
                if (in_valid) begin
                    lvl_next = level_in;
                    st_next  = S_UPD;
                end
            end
            S_UPD: begin
                if (attack) begin
                    phase_next = PH_HOLD;
                    hcnt_next  = '0;
                    coef_next  = cfg.attack_coef;
                    st_next    = S_POLE1;
                end else if (phase_reg == PH_HOLD) begin
                    hcnt_next = hcnt_reg + 1'b1;
                    if (hcnt_next > (HOLD_BITS+1)'(hold_count)) begin
                        phase_next = PH_RELEASE;
                    end
                    st_next = S_NORM0;
                end else begin
                    hcnt_next = '0;
                    coef_next = cfg.release_coef;
                    st_next   = S_POLE1;
                end
            end
            S_POLE1: begin
                acc_next = pu[56:0];
                st_next  = S_POLE2;
            end
            S_POLE2: begin
                sum_w    = PROD_W'(acc_reg) + pu + PROD_W'(1 << 23);
                env_next = sum_w[24 +: LEVEL_BITS];
                st_next  = S_NORM0;
            end
            S_NORM0: begin
                if (env_reg == '0) begin
                    db_next = DB_FLOOR;
                    st_next = S_GAIN0;
                end else begin
                    norm_next = env_reg;
                    p_next    = PW'(LEVEL_BITS - 1);
                    st_next   = S_NORM;
                end
            end
            S_NORM: begin
                if (norm_reg[LEVEL_BITS-1]) begin
                    m_next    = aligned[31:1];
                    cnt_next  = '0;
                    frac_next = '0;
                    st_next   = S_SQR;
                end else begin
                    norm_next = norm_reg << 1;
                    p_next    = p_reg - 1'b1;
                end
            end
            S_SQR: begin
                sq        = pu[61:30];
                m_next    = sq[31] ? sq[31:1] : sq[30:0];
                frac_next = {frac_reg[14:0], sq[31]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 5'd15) begin
                    st_next = S_DB;
                end
            end
            S_DB: begin
                sum_w   = pu + PROD_W'(1 << 23);
                dbm     = sum_w[40:24];
                db_next = (dbm > 17'd25600) ? DB_FLOOR : 16'(-$signed({1'b0, dbm}));
                st_next = S_GAIN0;
            end
            S_GAIN0: begin
                x_next = x_w;
                if (cfg.knee_width_db == '0) begin
                    if (db_reg < cfg.threshold_db) begin
                        gdb_next = $signed({7'b0, cfg.makeup_db});
                        st_next  = S_L2;
                    end else begin
                        v_next  = 19'(x_w);
                        st_next = S_SLOPE;
                    end
                end else if (e2 < t2m) begin
                    gdb_next = $signed({7'b0, cfg.makeup_db});
                    st_next  = S_L2;
                end else if (e2 > t2p) begin
                    v_next  = 19'(x_w);
                    st_next = S_SLOPE;
                end else begin
                    rem_next = 13'(ax);
                    q_next   = '0;
                    cnt_next = '0;
                    st_next  = S_DIV;
                end
            end
            S_DIV: begin
                if (rem2 >= {1'b0, cfg.knee_width_db}) begin
                    rem_next = 13'(rem2 - {1'b0, cfg.knee_width_db});
                    q_next   = {q_reg[14:0], 1'b1};
                end else begin
                    rem_next = rem2[12:0];
                    q_next   = {q_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd15) begin
                    st_next = S_COSY;
                end
            end
            S_COSY: begin
                sum_w   = pu + PROD_W'(32768);
                y_next  = sum_w[33:16];
                st_next = S_COSZ;
            end
            S_COSZ: begin
                sum_w   = pu + PROD_W'(32768);
                z_next  = sum_w[33:16];
                st_next = S_COSA;
            end
            S_COSA: begin
                acc_next = 57'(24'd23302 - pu[39:16]);
                st_next  = S_COSB;
            end
            S_COSB: begin
                acc_next = 57'(24'd699051 - pu[39:16]);
                st_next  = S_COSC;
            end
            S_COSC: begin
                acc_next = 57'(24'd8388608 - pu[39:16]);
                st_next  = S_COSD;
            end
            S_COSD: begin
                acc_next = 57'(pu[47:24]);
                st_next  = S_COSV;
            end
            S_COSV: begin
                sum_w   = pu + PROD_W'(65536);
                v_next  = 19'(x_reg) + $signed({4'b0, sum_w[31:17]});
                st_next = S_SLOPE;
            end
            S_SLOPE: begin
                rr       = rround(mul_p, 15);
                gdb_next = 20'(rr) + $signed({7'b0, cfg.makeup_db});
                st_next  = S_L2;
            end
            S_L2: begin
                rr = rround(mul_p, 12);
                if (rr >= PROD_W'(262144)) begin
                    gain_next = 24'hFFFFFF;
                    st_next   = S_OUT;
                end else if (rr < -PROD_W'(1376256)) begin
                    gain_next = '0;
                    st_next   = S_OUT;
                end else begin
                    off      = 21'(rr + PROD_W'(1376256));
                    f_next   = off[15:0];
                    n_next   = 5'd25 - off[20:16];
                    acc_next = 57'(2584);
                    cnt_next = '0;
                    st_next  = S_HORN;
                end
            end
            S_HORN: begin
                acc_next = 57'(HORNER_C[cnt_reg[2:0]] + pu[41:16]);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd5) begin
                    st_next = S_FIN;
                end
            end
            S_FIN: begin
                fsum      = 27'(acc_reg[25:0]) + (27'(1) << (n_reg - 1'b1));
                fsh       = fsum >> n_reg;
                gain_next = (fsh > 27'hFFFFFF) ? 24'hFFFFFF : fsh[23:0];
                st_next   = S_OUT;
            end
            S_OUT: begin
                if (!ovalid_reg || out_ready) begin
                    ovalid_next = 1'b1;
                    ogain_next  = gain_reg;
                    oenv_next   = env_reg;
                    st_next     = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= S_IDLE;
            env_reg    <= '0;
            phase_reg  <= PH_RELEASE;
            hcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            st_reg     <= st_next;
            env_reg    <= env_next;
            phase_reg  <= phase_next;
            hcnt_reg   <= hcnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg   <= lvl_next;
        coef_reg  <= coef_next;
        acc_reg   <= acc_next;
        norm_reg  <= norm_next;
        p_reg     <= p_next;
        m_reg     <= m_next;
        frac_reg  <= frac_next;
        cnt_reg   <= cnt_next;
        db_reg    <= db_next;
        x_reg     <= x_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        v_reg     <= v_next;
        gdb_reg   <= gdb_next;
        f_reg     <= f_next;
        n_reg     <= n_next;
        gain_reg  <= gain_next;
        ogain_reg <= ogain_next;
        oenv_reg  <= oenv_next;
    end

    assign in_ready     = (st_reg == S_IDLE);
    assign out_valid    = ovalid_reg;
    assign gain_out     = ogain_reg;
    assign envelope_out = oenv_reg;

endmodule
